### sv/dqs_pkg.sv
// Shared types, codes and defaults for the deque with linear search.
`default_nettype none

package dqs_pkg;

  localparam int unsigned DEPTH_DEF       = 16;
  localparam int unsigned VALUE_WIDTH_DEF = 32;

  localparam int unsigned FUNC_W   = 3;
  localparam int unsigned DATA_W   = 32;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned POS_W    = 5;

  localparam logic [FUNC_W-1:0] FN_PUSH_FRONT = 3'd0;
  localparam logic [FUNC_W-1:0] FN_PUSH_BACK  = 3'd1;
  localparam logic [FUNC_W-1:0] FN_POP_FRONT  = 3'd2;
  localparam logic [FUNC_W-1:0] FN_POP_BACK   = 3'd3;
  localparam logic [FUNC_W-1:0] FN_SEARCH     = 3'd4;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;
  localparam logic [STATUS_W-1:0] ST_MISS  = 2'd3;

  // Command broadcast to every cell for one cycle.
  typedef struct packed {
    logic shift_right;  // push at the front
    logic shift_left;   // pop at the front
    logic write_back;   // write into the cell at the occupancy index
  } cmd_t;

  // Search token handed from cell to cell.
  typedef struct packed {
    logic             active;
    logic             found;
    logic [POS_W-1:0] pos;
  } wave_t;

endpackage

`default_nettype wire

### sv/dqs_cell.sv
// One storage cell of the deque: holds one entry and passes the search token on.
`default_nettype none

module dqs_cell import dqs_pkg::*; #(
  parameter int unsigned VALUE_WIDTH = VALUE_WIDTH_DEF,
  parameter int unsigned OCC_W       = 5,
  parameter int unsigned INDEX       = 0
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire cmd_t                   cmd_i,
  input  wire logic [OCC_W-1:0]       occ_i,
  input  wire logic [VALUE_WIDTH-1:0] wr_data_i,
  input  wire logic [VALUE_WIDTH-1:0] key_i,
  input  wire logic [VALUE_WIDTH-1:0] prev_val_i,
  input  wire logic [VALUE_WIDTH-1:0] next_val_i,
  output logic      [VALUE_WIDTH-1:0] val_o,
  input  wire wave_t                  wave_i,
  output wave_t                       wave_o
);

  localparam logic [POS_W-1:0] MyPos   = POS_W'(INDEX + 1);
  localparam logic [OCC_W-1:0] MyIndex = OCC_W'(INDEX);

  logic [VALUE_WIDTH-1:0] val_q, val_d;
  wave_t                  wave_q, wave_d;
  logic                   occupied;

  assign occupied = (occ_i > MyIndex);

  always_comb begin
    val_d = val_q;
    if (cmd_i.shift_right) begin
      val_d = prev_val_i;
    end else if (cmd_i.shift_left) begin
      val_d = next_val_i;
    end else if (cmd_i.write_back && (occ_i == MyIndex)) begin
      val_d = wr_data_i;
    end
  end

  always_comb begin
    wave_d = wave_i;
    if (wave_i.active && !wave_i.found && occupied && (val_q == key_i)) begin
      wave_d.found = 1'b1;
      wave_d.pos   = MyPos;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wave_q <= '0;
    end else begin
      wave_q <= wave_d;
    end
  end

  assign val_o  = val_q;
  assign wave_o = wave_q;

endmodule

`default_nettype wire

### sv/deque_with_linear_search.sv
// Top level of the bounded double-ended queue with linear search.
`default_nettype none

// The queue is a row of DEPTH cells with the front entry in cell 0. A push or
// pop takes one beat in and gives its result beat on the next cycle; the cells
// shift as a whole for front operations. A search of a non-empty queue sends
// a token down the row, one cell per cycle, and its result waits until the
// token leaves the last cell, whatever the occupancy. One item is worked on
// at a time: a new input beat is taken once the previous search has finished
// and the output register is free or being emptied. Values are sign-extended
// from 32 bits and kept in VALUE_WIDTH bits.
module deque_with_linear_search import dqs_pkg::*; #(
  parameter int unsigned DEPTH       = DEPTH_DEF,
  parameter int unsigned VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       in_valid_i,
  output logic                            in_ready_o,
  input  wire logic        [FUNC_W-1:0]   func_i,
  input  wire logic signed [DATA_W-1:0]   value_i,
  output logic                            out_valid_o,
  input  wire logic                       out_ready_i,
  output logic             [STATUS_W-1:0] status_o,
  output logic             [POS_W-1:0]    position_o
);

  localparam int unsigned OCC_W = $clog2(DEPTH + 1);
  localparam logic [OCC_W-1:0] OccFull = OCC_W'(DEPTH);

  localparam logic S_IDLE   = 1'b0;
  localparam logic S_SEARCH = 1'b1;

  logic                   state_q, state_d;
  logic [OCC_W-1:0]       occ_q, occ_d;
  logic [VALUE_WIDTH-1:0] key_q, key_d;
  logic                   start_q, start_d;
  logic                   out_valid_q, out_valid_d;
  logic [STATUS_W-1:0]    status_q, status_d;
  logic [POS_W-1:0]       pos_q, pos_d;

  logic [63:0]            value_ext;
  logic [VALUE_WIDTH-1:0] in_data;
  logic                   accept;
  logic                   is_full, is_empty;
  cmd_t                   cmd;

  logic [VALUE_WIDTH-1:0] cell_val [DEPTH];
  wave_t                  chain    [DEPTH+1];
  wave_t                  wave_end;

  assign value_ext = {{(64 - DATA_W){value_i[DATA_W-1]}}, value_i};
  assign in_data   = value_ext[VALUE_WIDTH-1:0];

  assign in_ready_o = (state_q == S_IDLE) && (!out_valid_q || out_ready_i);
  assign accept     = in_valid_i && in_ready_o;
  assign is_full    = (occ_q == OccFull);
  assign is_empty   = (occ_q == '0);

  assign chain[0] = '{active: start_q, found: 1'b0, pos: '0};
  assign wave_end = chain[DEPTH];

  always_comb begin
    state_d     = state_q;
    occ_d       = occ_q;
    key_d       = key_q;
    start_d     = 1'b0;
    out_valid_d = out_valid_q;
    status_d    = status_q;
    pos_d       = pos_q;
    cmd         = '0;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    if (accept) begin
      status_d = ST_OK;
      pos_d    = '0;
      out_valid_d = 1'b1;
      case (func_i)
        FN_PUSH_FRONT: begin
          if (is_full) begin
            status_d = ST_FULL;
          end else begin
            cmd.shift_right = 1'b1;
            occ_d = occ_q + 1'b1;
          end
        end
        FN_PUSH_BACK: begin
          if (is_full) begin
            status_d = ST_FULL;
          end else begin
            cmd.write_back = 1'b1;
            occ_d = occ_q + 1'b1;
          end
        end
        FN_POP_FRONT: begin
          if (is_empty) begin
            status_d = ST_EMPTY;
          end else begin
            cmd.shift_left = 1'b1;
            occ_d = occ_q - 1'b1;
          end
        end
        FN_POP_BACK: begin
          if (is_empty) begin
            status_d = ST_EMPTY;
          end else begin
            occ_d = occ_q - 1'b1;
          end
        end
        FN_SEARCH: begin
          if (is_empty) begin
            status_d = ST_EMPTY;
          end else begin
            // The result waits for the token to leave the last cell.
            out_valid_d = 1'b0;
            key_d       = in_data;
            start_d     = 1'b1;
            state_d     = S_SEARCH;
          end
        end
        default: begin
        end
      endcase
    end

    if (wave_end.active) begin
      out_valid_d = 1'b1;
      status_d    = wave_end.found ? ST_OK : ST_MISS;
      pos_d       = wave_end.found ? wave_end.pos : '0;
      state_d     = S_IDLE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      occ_q       <= '0;
      start_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      occ_q       <= occ_d;
      start_q     <= start_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q    <= key_d;
    status_q <= status_d;
    pos_q    <= pos_d;
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [VALUE_WIDTH-1:0] prev_val, next_val;

    if (i == 0) begin : g_head
      assign prev_val = in_data;
    end else begin : g_body
      assign prev_val = cell_val[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign next_val = cell_val[i];
    end else begin : g_inner
      assign next_val = cell_val[i+1];
    end

    dqs_cell #(
      .VALUE_WIDTH (VALUE_WIDTH),
      .OCC_W       (OCC_W),
      .INDEX       (i)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .cmd_i      (cmd),
      .occ_i      (occ_q),
      .wr_data_i  (in_data),
      .key_i      (key_q),
      .prev_val_i (prev_val),
      .next_val_i (next_val),
      .val_o      (cell_val[i]),
      .wave_i     (chain[i]),
      .wave_o     (chain[i+1])
    );
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign position_o  = pos_q;

  a_occ_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q <= OccFull)
    else $error("occupancy exceeds the depth");

  a_wave_in_search: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wave_end.active |-> (state_q == S_SEARCH))
    else $error("search token left the row outside a search");

  a_out_free_at_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wave_end.active |-> !out_valid_q)
    else $error("search finished while the output register was still full");

  a_search_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (func_i == FN_SEARCH) && !is_empty) |=> !in_ready_o)
    else $error("input taken while a search was starting");

endmodule

`default_nettype wire

### tb/testbench.sv
// Self-checking testbench for the deque with linear search: directed table, then random traffic.
`timescale 1ns / 1ps

module testbench;
  import dqs_pkg::*;

  localparam int unsigned DEPTH       = DEPTH_DEF;
  localparam int          RANDOM_OPS  = 950;
  localparam int          CYCLE_LIMIT = 500000;
  localparam int          PRINT_LIMIT = 40;

  // Function codes above the search code are ignored by the block.
  localparam logic [FUNC_W-1:0] FN_UNUSED_LO = 3'd5;
  localparam logic [FUNC_W-1:0] FN_UNUSED_HI = 3'd7;

  localparam logic [DATA_W-1:0] V_MIN  = 32'h8000_0000;
  localparam logic [DATA_W-1:0] V_MAX  = 32'h7fff_ffff;
  localparam logic [DATA_W-1:0] V_NEG1 = 32'hffff_ffff;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [POS_W-1:0]    position;
  } deque_result_t;

  typedef struct {
    bit            typed;
    deque_result_t want;
  } beat_note_t;

  typedef struct {
    logic [FUNC_W-1:0]   fn;
    logic [DATA_W-1:0]   val;
    int                  reps;
    bit                  typed;
    logic [STATUS_W-1:0] st;
    logic [POS_W-1:0]    pos;
  } dir_row_t;

  logic                       clk_i;
  logic                       rst_ni;
  logic                       in_valid_i;
  logic                       in_ready_o;
  logic        [FUNC_W-1:0]   func_i;
  logic signed [DATA_W-1:0]   value_i;
  logic                       out_valid_o;
  logic                       out_ready_i;
  logic        [STATUS_W-1:0] status_o;
  logic        [POS_W-1:0]    position_o;

  // Mirror of the queue contents, updated on every accepted input beat.
  logic [DATA_W-1:0] mirror_store [DEPTH];
  int                mirror_front;
  int                mirror_count;

  deque_result_t pending_results [$];
  beat_note_t    beat_notes [$];
  int            mismatches;
  int            results_seen;
  int            cycle_count;
  int            burst_left;
  dir_row_t      dir_rows [22];

  deque_with_linear_search dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .func_i      (func_i),
    .value_i     (value_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_o    (status_o),
    .position_o  (position_o)
  );

  initial clk_i = 1'b0;
  always #10 clk_i = ~clk_i;

  function automatic deque_result_t deque_apply(logic [FUNC_W-1:0] fn,
                                                logic [DATA_W-1:0] val);
    deque_result_t r;
    int            k;
    r.status   = ST_OK;
    r.position = '0;
    case (fn)
      FN_PUSH_FRONT: begin
        if (mirror_count >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          mirror_front = (mirror_front + DEPTH - 1) % DEPTH;
          mirror_store[mirror_front] = val;
          mirror_count++;
        end
      end
      FN_PUSH_BACK: begin
        if (mirror_count >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          mirror_store[(mirror_front + mirror_count) % DEPTH] = val;
          mirror_count++;
        end
      end
      FN_POP_FRONT: begin
        if (mirror_count == 0) begin
          r.status = ST_EMPTY;
        end else begin
          mirror_front = (mirror_front + 1) % DEPTH;
          mirror_count--;
        end
      end
      FN_POP_BACK: begin
        if (mirror_count == 0) r.status = ST_EMPTY;
        else mirror_count--;
      end
      FN_SEARCH: begin
        if (mirror_count == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.status = ST_MISS;
          for (k = 0; k < mirror_count; k++) begin
            if (mirror_store[(mirror_front + k) % DEPTH] == val) begin
              r.status   = ST_OK;
              r.position = POS_W'(k + 1);
              break;
            end
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    if (mismatches < PRINT_LIMIT) begin
      $display("MISMATCH at cycle %0d: %s got %0d expected %0d", cycle_count, what, got, want);
    end
    mismatches++;
  endtask

  // Input and output beats are both observed here, at the rising edge.
  always @(posedge clk_i) begin
    deque_result_t predicted;
    deque_result_t oldest;
    beat_note_t    note;
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("testbench: FAIL");
      $finish;
    end
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        results_seen++;
        if (pending_results.size() == 0) begin
          report_mismatch("unexpected result beat, status", status_o, 0);
        end else begin
          oldest = pending_results.pop_front();
          if (status_o !== oldest.status) report_mismatch("status", status_o, oldest.status);
          if (position_o !== oldest.position) begin
            report_mismatch("position", position_o, oldest.position);
          end
        end
      end
      if (in_valid_i && in_ready_o) begin
        predicted = deque_apply(func_i, value_i);
        note = beat_notes.pop_front();
        pending_results.push_back(note.typed ? note.want : predicted);
      end
    end
  end

  // Offer one beat and hold it until accepted, then pace the next one.
  task automatic send_beat(input logic [FUNC_W-1:0] fn, input logic [DATA_W-1:0] val,
                           input bit typed, input deque_result_t want);
    int gap;
    beat_notes.push_back('{typed, want});
    in_valid_i <= 1'b1;
    func_i     <= fn;
    value_i    <= val;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    @(negedge clk_i);
    burst_left--;
    if (burst_left <= 0) begin
      gap = $urandom_range(1, 8);
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 24);
    end
  endtask

  // Receiver: stretches with their own stall rate, plus one long hold-off.
  initial begin
    int  stretch_left;
    int  stall_pct;
    int  hold_left;
    bit  hold_done;
    stretch_left = 0;
    stall_pct    = 0;
    hold_left    = 0;
    hold_done    = 1'b0;
    out_ready_i  = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (!hold_done && results_seen >= 150) begin
        hold_done = 1'b1;
        hold_left = 400;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        if (stretch_left <= 0) begin
          stretch_left = $urandom_range(10, 60);
          case ($urandom_range(0, 2))
            0: stall_pct = 0;
            1: stall_pct = 25;
            default: stall_pct = 60;
          endcase
        end
        stretch_left--;
        out_ready_i <= ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  initial begin
    deque_result_t     none;
    logic [FUNC_W-1:0] fn;
    logic [DATA_W-1:0] val;
    int                ops_left;
    int                mode;
    int                mode_left;
    int                pick;
    int                i;

    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    func_i       = '0;
    value_i      = '0;
    mismatches   = 0;
    results_seen = 0;
    cycle_count  = 0;
    burst_left   = 4;
    mirror_front = 0;
    mirror_count = 0;
    none         = '0;
    for (i = 0; i < DEPTH; i++) mirror_store[i] = '0;

    // Empty queue, ignored codes, a fill to full, searches that hit the second
    // entry, the middle and the very last entry and one that misses, then a few pops.
    dir_rows = '{
      '{FN_POP_FRONT,  32'h0,         1,  1'b1, ST_EMPTY, 5'd0},
      '{FN_POP_BACK,   32'h0,         1,  1'b1, ST_EMPTY, 5'd0},
      '{FN_SEARCH,     32'h0,         1,  1'b1, ST_EMPTY, 5'd0},
      '{FN_UNUSED_LO,  V_NEG1,        1,  1'b1, ST_OK,    5'd0},
      '{FN_UNUSED_HI,  V_MIN,         1,  1'b1, ST_OK,    5'd0},
      '{FN_PUSH_FRONT, V_MIN,         1,  1'b1, ST_OK,    5'd0},
      '{FN_PUSH_BACK,  V_MAX,         1,  1'b1, ST_OK,    5'd0},
      '{FN_PUSH_FRONT, 32'h0,         1,  1'b1, ST_OK,    5'd0},
      '{FN_PUSH_BACK,  V_NEG1,        1,  1'b1, ST_OK,    5'd0},
      '{FN_PUSH_BACK,  32'h55,        11, 1'b1, ST_OK,    5'd0},
      '{FN_PUSH_BACK,  32'haaaa,      1,  1'b1, ST_OK,    5'd0},
      '{FN_PUSH_FRONT, 32'h1,         1,  1'b1, ST_FULL,  5'd0},
      '{FN_PUSH_BACK,  32'h1,         1,  1'b1, ST_FULL,  5'd0},
      '{FN_SEARCH,     V_MIN,         1,  1'b1, ST_OK,    5'd2},
      '{FN_SEARCH,     V_NEG1,        1,  1'b1, ST_OK,    5'd4},
      '{FN_SEARCH,     32'haaaa,      1,  1'b1, ST_OK,    5'd16},
      '{FN_SEARCH,     32'h55,        1,  1'b1, ST_OK,    5'd5},
      '{FN_SEARCH,     32'h1234_5678, 1,  1'b1, ST_MISS,  5'd0},
      '{FN_POP_FRONT,  32'h0,         1,  1'b1, ST_OK,    5'd0},
      '{FN_POP_BACK,   32'h0,         1,  1'b1, ST_OK,    5'd0},
      '{FN_SEARCH,     V_MAX,         1,  1'b0, ST_OK,    5'd0},
      '{FN_PUSH_FRONT, 32'hffff_fffb, 1,  1'b0, ST_OK,    5'd0}
    };

    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (dir_rows[r]) begin
      repeat (dir_rows[r].reps) begin
        send_beat(dir_rows[r].fn, dir_rows[r].val, dir_rows[r].typed,
                  '{dir_rows[r].st, dir_rows[r].pos});
      end
    end

    // Random traffic in fill, drain and mixed phases so occupancy sweeps
    // the whole range; searches mostly look for values that are stored.
    ops_left  = RANDOM_OPS;
    mode      = 0;
    mode_left = 0;
    while (ops_left > 0) begin
      if (mode_left <= 0) begin
        mode      = $urandom_range(0, 2);
        mode_left = $urandom_range(10, 40);
      end
      mode_left--;
      pick = $urandom_range(0, 99);
      if (pick < 3) begin
        fn = FUNC_W'($urandom_range(FN_UNUSED_LO, FN_UNUSED_HI));
      end else begin
        pick = $urandom_range(0, 99);
        case (mode)
          0: fn = (pick < 60) ? FN_PUSH_FRONT : (pick < 85) ? FN_SEARCH : FN_POP_FRONT;
          1: fn = (pick < 60) ? FN_POP_FRONT : (pick < 85) ? FN_SEARCH : FN_PUSH_FRONT;
          default: fn = (pick < 30) ? FN_PUSH_FRONT : (pick < 60) ? FN_POP_FRONT : FN_SEARCH;
        endcase
        // Front and back variants are chosen evenly.
        if (fn != FN_SEARCH && $urandom_range(0, 1) == 1) fn = fn + 1'b1;
        ops_left--;
      end
      pick = $urandom_range(0, 99);
      if (fn == FN_SEARCH && mirror_count > 0 && pick < 60) begin
        val = mirror_store[(mirror_front + $urandom_range(0, mirror_count - 1)) % DEPTH];
      end else if (pick < 80) begin
        val = DATA_W'($urandom_range(0, 7));
      end else if (pick < 90) begin
        case ($urandom_range(0, 3))
          0: val = V_MIN;
          1: val = V_MAX;
          2: val = V_NEG1;
          default: val = '0;
        endcase
      end else begin
        val = $urandom;
      end
      send_beat(fn, val, 1'b0, none);
    end

    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DEPTH * 4) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule

### files.f
sv/dqs_pkg.sv
sv/dqs_cell.sv
sv/deque_with_linear_search.sv
tb/testbench.sv
